>>> hw/rtl/quoted_list_tokenizer_unit_assert.svh
// ----------------------------------------------------------------------------
// Quoted list tokenizer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef QUOTED_LIST_TOKENIZER_UNIT_ASSERT_SVH
`define QUOTED_LIST_TOKENIZER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define QLT_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("quoted list tokenizer check failed");

// Next-cycle implication.
`define QLT_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("quoted list tokenizer check failed");

`endif

>>> hw/rtl/qlt_pkg.sv
// ----------------------------------------------------------------------------
// Quoted list tokenizer package
// Byte codes, parser mode codes, result types and the per-byte step helpers.
// ----------------------------------------------------------------------------
package qlt_pkg;

	localparam logic [7:0] QUOTE_BYTE = 8'h22;
	localparam logic [7:0] TERM_BYTE  = 8'h00;
	localparam logic [7:0] SEP_RESET  = 8'd44;

	// Parser mode codes.
	localparam logic [2:0] MODE_START  = 3'd0;
	localparam logic [2:0] MODE_NEXT   = 3'd1;
	localparam logic [2:0] MODE_PLAIN  = 3'd2;
	localparam logic [2:0] MODE_QUOTED = 3'd3;
	localparam logic [2:0] MODE_QSEEN  = 3'd4;
	localparam logic [2:0] MODE_AFTER  = 3'd5;
	localparam logic [2:0] MODE_ERROR  = 3'd6;

	// One result word.
	typedef struct packed {
		logic [7:0] char_out;
		logic       char_valid;
		logic       token_end;
		logic       list_end;
		logic       error_flag;
	} res_t;

	// Outcome of one byte: next mode, whether a word is produced, and the word.
	typedef struct packed {
		logic [2:0] mode;
		logic       has;
		res_t       res;
	} step_t;

	function automatic logic is_blank(input logic [7:0] b);
		return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D) || (b == 8'h0C);
	endfunction

	// Error at byte b: report it; end the list if b is the terminator, else wait.
	function automatic step_t fail_step(input logic [7:0] b);
		step_t s;
		s = '0;
		s.has = 1'b1;
		s.res.error_flag = 1'b1;
		if (b == TERM_BYTE) begin
			s.mode = MODE_START;
			s.res.list_end = 1'b1;
		end else begin
			s.mode = MODE_ERROR;
		end
		return s;
	endfunction

	// Byte after a complete name, trailing whitespace allowed.
	function automatic step_t after_step(input logic [7:0] b, input logic [7:0] sep);
		step_t s;
		s = '0;
		if (b == TERM_BYTE) begin
			s.mode = MODE_START;
			s.has = 1'b1;
			s.res.token_end = 1'b1;
			s.res.list_end = 1'b1;
		end else if (is_blank(b)) begin
			s.mode = MODE_AFTER;
		end else if (b == sep) begin
			s.mode = MODE_NEXT;
			s.has = 1'b1;
			s.res.token_end = 1'b1;
		end else begin
			s = fail_step(b);
		end
		return s;
	endfunction

	// Byte where a name is expected.
	function automatic step_t start_step(input logic [7:0] b, input logic [7:0] sep,
			input logic first);
		step_t s;
		s = '0;
		if (b == TERM_BYTE) begin
			if (first) begin
				s.mode = MODE_START;
				s.has = 1'b1;
				s.res.list_end = 1'b1;
			end else begin
				s = fail_step(b);
			end
		end else if (is_blank(b)) begin
			s.mode = first ? MODE_START : MODE_NEXT;
		end else if (b == QUOTE_BYTE) begin
			s.mode = MODE_QUOTED;
		end else if (b == sep) begin
			s = fail_step(b);
		end else begin
			s.mode = MODE_PLAIN;
			s.has = 1'b1;
			s.res.char_out = b;
			s.res.char_valid = 1'b1;
		end
		return s;
	endfunction

endpackage

>>> hw/rtl/quoted_list_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// Quoted list tokenizer unit
// Splits a zero-terminated byte string into names at a separator byte,
// handling blanks around names and double-quoted names with doubled quotes.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes enter on the s_* channel, one word per byte, s_tdata is the byte.
//   A zero byte ends the string. Each byte gives zero or one result word on
//   the m_* channel: m_tdata is the name character, m_tuser holds char_valid,
//   token_end and error_flag, and m_tlast marks the end of the list.
//   On error_flag the consumer drops the characters of the whole list.
//   The separator is written on cfg_valid/cfg_data while the block is idle;
//   cfg_ready is always high.
// Timing:
//   A byte is held in the input register, and its result word is loaded
//   into the output register once that register is free or being read.
//   One byte is taken every cycle while result words are taken; the
//   single parser state register sets that rate.
// Reset and stall:
//   Reset empties both registers, sets the parser to the start of a string
//   and the separator to a comma. While the output word waits, the byte in
//   the input register holds and s_tready falls until the word is taken.
// ----------------------------------------------------------------------------
module quoted_list_tokenizer_unit
	import qlt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	// Configuration: separator byte.
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data,
	// Input bytes. s_tdata: [7:0] in_byte.
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,
	// Results. m_tdata: [7:0] char_out.
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	// m_tuser: [0] char_valid, [1] token_end, [2] error_flag.
	output logic [2:0] m_tuser,
	output logic       m_tlast
);

	logic [7:0] sep_q;
	logic [2:0] mode_q;
	logic       byte_vld_s1;
	logic [7:0] byte_s1;
	logic       out_vld_q;
	res_t       out_q;
	logic       advance;
	step_t      step;

	assign cfg_ready = 1'b1;

	// Separator register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q <= SEP_RESET;
		end else if (cfg_valid) begin
			sep_q <= cfg_data;
		end
	end

	// The held byte moves on when the output register is free or being read.
	assign advance  = byte_vld_s1 && (!out_vld_q || m_tready);
	assign s_tready = !byte_vld_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_vld_s1 <= 1'b0;
		end else if (s_tready) begin
			byte_vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	// Parser step for the held byte.
	always_comb begin
		step = '0;
		step.mode = mode_q;
		case (mode_q)
			MODE_NEXT: begin
				step = start_step(byte_s1, sep_q, 1'b0);
			end
			MODE_PLAIN: begin
				if (byte_s1 == TERM_BYTE || is_blank(byte_s1) || byte_s1 == sep_q) begin
					step = after_step(byte_s1, sep_q);
				end else begin
					step.has = 1'b1;
					step.res.char_out = byte_s1;
					step.res.char_valid = 1'b1;
				end
			end
			MODE_QUOTED: begin
				if (byte_s1 == TERM_BYTE) begin
					step = fail_step(byte_s1);
				end else if (byte_s1 == QUOTE_BYTE) begin
					step.mode = MODE_QSEEN;
				end else begin
					step.has = 1'b1;
					step.res.char_out = byte_s1;
					step.res.char_valid = 1'b1;
				end
			end
			MODE_QSEEN: begin
				if (byte_s1 == QUOTE_BYTE) begin
					step.mode = MODE_QUOTED;
					step.has = 1'b1;
					step.res.char_out = QUOTE_BYTE;
					step.res.char_valid = 1'b1;
				end else begin
					step = after_step(byte_s1, sep_q);
				end
			end
			MODE_AFTER: begin
				step = after_step(byte_s1, sep_q);
			end
			MODE_ERROR: begin
				if (byte_s1 == TERM_BYTE) begin
					step.mode = MODE_START;
					step.has = 1'b1;
					step.res.list_end = 1'b1;
					step.res.error_flag = 1'b1;
				end
			end
			default: begin
				step = start_step(byte_s1, sep_q, 1'b1);
			end
		endcase
	end

	// Parser mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_START;
		end else if (advance) begin
			mode_q <= step.mode;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance && step.has) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step.has) begin
			out_q <= step.res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q.char_out;
	assign m_tuser  = {out_q.error_flag, out_q.token_end, out_q.char_valid};
	assign m_tlast  = out_q.list_end;

	// Checks.
`include "quoted_list_tokenizer_unit_assert.svh"

	// A character word carries no end or error marks.
	`QLT_ASSERT_IMP(a_char_alone, m_tvalid && m_tuser[0], !m_tlast && m_tuser[2:1] == 2'b00)
	// Words without a character carry a zero byte.
	`QLT_ASSERT_IMP(a_char_zero, m_tvalid && !m_tuser[0], m_tdata == 8'h00)
	// A list end returns the parser to the start of a string.
	`QLT_ASSERT_NXT(a_list_restart, advance && step.has && step.res.list_end,
		mode_q == MODE_START)
	// In error mode the only word is the final error and list end.
	`QLT_ASSERT_IMP(a_error_quiet, advance && mode_q == MODE_ERROR && step.has,
		step.res.list_end && step.res.error_flag)

endmodule
